FILE: design/dam_pkg.sv
// Shared types and constants for the door-open alarm monitor.
`timescale 1ns / 1ps
`default_nettype none

package dam_pkg;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_STOP   = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_OPEN_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_OPEN_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_CLOSE_LIMIT    = 2'd2;

   localparam int unsigned CSR_DATA_W = 16;

   localparam logic signed [7:0] THRESHOLD_RESET   = 8'sd50;
   localparam logic [15:0]       OPEN_LIMIT_RESET  = 16'd240;
   localparam logic [7:0]        CLOSE_LIMIT_RESET = 8'd40;
   localparam logic signed [7:0] AVERAGE_START     = 8'sd25;

   typedef struct packed {
      logic signed [7:0] open_threshold;
      logic [15:0]       open_limit;
      logic [7:0]        close_limit;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/dam_csr.sv
// Configuration registers of the door-open alarm monitor.
`timescale 1ns / 1ps
`default_nettype none

module dam_csr
   import dam_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_threshold <= THRESHOLD_RESET;
         cfg_ff.open_limit     <= OPEN_LIMIT_RESET;
         cfg_ff.close_limit    <= CLOSE_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPEN_THRESHOLD: cfg_ff.open_threshold <= signed'(csr_wdata[7:0]);
            CSR_OPEN_LIMIT:     cfg_ff.open_limit     <= csr_wdata[15:0];
            CSR_CLOSE_LIMIT:    cfg_ff.close_limit    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/dam_avg.sv
// Running-average update with signed division by the window, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module dam_avg #(
   parameter int unsigned AVG_WINDOW = 4
) (
   input  wire logic signed [7:0] avg_in,
   input  wire logic signed [7:0] sample,
   output logic signed [7:0]      avg_out
);

   localparam int unsigned ACC_W   = 9 + $clog2(AVG_WINDOW);
   localparam int unsigned SHIFT   = ACC_W + $clog2(AVG_WINDOW);
   localparam int unsigned RECIP_W = SHIFT + 1;
   localparam int unsigned PROD_W  = ACC_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));
   localparam logic signed [ACC_W-1:0] WEIGHT = ACC_W'(AVG_WINDOW - 1);

   logic signed [ACC_W-1:0] avg_ext;
   logic signed [ACC_W-1:0] sample_ext;
   logic signed [ACC_W-1:0] acc;
   logic                    neg;
   logic [ACC_W-1:0]        mag;
   logic [PROD_W-1:0]       prod;
   logic [7:0]              quot;

   // The magnitude is divided by a scaled reciprocal; the sign is put back after.
   always_comb begin
      avg_ext    = ACC_W'(avg_in);
      sample_ext = ACC_W'(sample);
      acc        = avg_ext * WEIGHT + sample_ext;
      neg        = acc[ACC_W-1];
      mag        = neg ? ACC_W'(-acc) : ACC_W'(acc);
      prod       = PROD_W'(mag) * PROD_W'(RECIP);
      quot       = prod[SHIFT+7:SHIFT];
      avg_out    = neg ? signed'(8'(-quot)) : signed'(quot);
   end

endmodule

`default_nettype wire

FILE: design/door_open_alarm_monitor.sv
// Top level of the door-open alarm monitor: request register, state update, response register.
// An accepted request is held in the request register; its result moves to the rsp_ registers.
// Throughput: one request per cycle unless stalled; the state update is one combinational pass.
// A stalled response holds the request register, which then raises req_stall.
// Reset is synchronous: both stages empty, registers and state at their reset values.
`timescale 1ns / 1ps
`default_nettype none

module door_open_alarm_monitor
   import dam_pkg::*;
#(
   parameter int unsigned AVG_WINDOW = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic signed [7:0]     req_ir_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_door_open,
   output logic                       rsp_buzzer_active,
   output logic                       rsp_lock_request,
   output logic signed [7:0]          rsp_average_value,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic              in_valid_ff;
   logic [1:0]        in_cmd_ff;
   logic signed [7:0] in_ir_ff;

   logic signed [7:0] avg_ff, avg_in;
   logic [15:0]       open_ticks_ff, open_ticks_in;
   logic [7:0]        closed_ticks_ff, closed_ticks_in;
   logic              door_ff, door_in;
   logic              buzzer_ff, buzzer_in;
   logic              lock_in;

   logic              out_valid_ff;
   logic              out_lock_ff;

   logic signed [7:0] avg_sample;
   logic              advance;
   logic              take;

   dam_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dam_avg #(
      .AVG_WINDOW (AVG_WINDOW)
   ) u_avg (
      .avg_in  (avg_ff),
      .sample  (in_ir_ff),
      .avg_out (avg_sample)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      avg_in          = avg_ff;
      open_ticks_in   = open_ticks_ff;
      closed_ticks_in = closed_ticks_ff;
      door_in         = door_ff;
      buzzer_in       = buzzer_ff;
      lock_in         = 1'b0;
      unique case (in_cmd_ff)
         CMD_START: begin
            avg_in          = AVERAGE_START;
            open_ticks_in   = '0;
            closed_ticks_in = '0;
         end
         CMD_SAMPLE: begin
            avg_in  = avg_sample;
            door_in = avg_sample < cfg.open_threshold;
            if (door_in) begin
               if (open_ticks_ff < cfg.open_limit) begin
                  open_ticks_in = open_ticks_ff + 16'd1;
               end else begin
                  buzzer_in = 1'b1;
               end
               closed_ticks_in = '0;
            end else begin
               buzzer_in     = 1'b0;
               open_ticks_in = '0;
               if (closed_ticks_ff < cfg.close_limit) begin
                  closed_ticks_in = closed_ticks_ff + 8'd1;
                  lock_in         = closed_ticks_in >= cfg.close_limit;
               end
            end
         end
         CMD_STOP: begin
            buzzer_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         avg_ff          <= AVERAGE_START;
         open_ticks_ff   <= '0;
         closed_ticks_ff <= '0;
         door_ff         <= 1'b0;
         buzzer_ff       <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff    <= 1'b1;
            avg_ff          <= avg_in;
            open_ticks_ff   <= open_ticks_in;
            closed_ticks_ff <= closed_ticks_in;
            door_ff         <= door_in;
            buzzer_ff       <= buzzer_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff <= req_cmd;
         in_ir_ff  <= req_ir_value;
      end
      if (advance) begin
         out_lock_ff <= lock_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_door_open     = door_ff;
   assign rsp_buzzer_active = buzzer_ff;
   assign rsp_lock_request  = out_lock_ff;
   assign rsp_average_value = avg_ff;

endmodule

`default_nettype wire

FILE: design/dam_checker.sv
// Port-level checks on the door-open alarm monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dam_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_door_open,
   input wire logic              rsp_buzzer_active,
   input wire logic              rsp_lock_request,
   input wire logic signed [7:0] rsp_average_value
);

   // A stalled response keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_door_open)
         && $stable(rsp_buzzer_active) && $stable(rsp_lock_request)
         && $stable(rsp_average_value))
      else $error("response changed while stalled");

   // The buzzer can only be on while the door reads open.
   a_buzzer_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buzzer_active |-> rsp_door_open)
      else $error("buzzer on with the door closed");

   // A lock request is only issued on a closed tick.
   a_lock_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_request |-> !rsp_door_open && !rsp_buzzer_active)
      else $error("lock request while the door is open");

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind door_open_alarm_monitor dam_checker u_dam_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_door_open     (rsp_door_open),
   .rsp_buzzer_active (rsp_buzzer_active),
   .rsp_lock_request  (rsp_lock_request),
   .rsp_average_value (rsp_average_value)
);

`default_nettype wire
